// ----- sv/rmst_pkg.sv -----
// Package for the range-minimum segment tree unit.
// Holds the tree geometry, the stored pair type, command codes and stream widths.
// No dependencies.
package rmst_pkg;

  // Tree geometry: leaves, heap-ordered node index and memory address widths
  localparam int LEAVES      = 1024;
  localparam int LEAF_LOG2   = $clog2(LEAVES);
  localparam int ADDR_W      = LEAF_LOG2 + 1;   // node addresses 0 .. 2*LEAVES-1
  localparam int NODE_W      = LEAF_LOG2 + 2;   // node bounds up to 2*LEAVES
  localparam int POS_W       = 10;
  localparam int SIZE_W      = 11;

  // Stored pair: signed value plus index tag
  localparam int VAL_W       = 32;
  localparam int TAG_W       = 10;
  localparam int PAIR_W      = VAL_W + TAG_W;

  // Stream data widths, padded to whole bytes
  localparam int IN_FIELDS_W = POS_W + 32 + TAG_W + SIZE_W + SIZE_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 32 + TAG_W;
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [SIZE_W-1:0] ACTIVE_RESET = SIZE_W'(LEAVES);

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [TAG_W-1:0]        tag;
  } pair_t;

  // Empty element: largest value, tag zero
  localparam pair_t EMPTY_PAIR = '{value: {1'b0, {(VAL_W-1){1'b1}}}, tag: '0};

  // Command codes carried in tuser
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_UP    = 5'b00100,
    ST_QRY   = 5'b01000,
    ST_SPARE = 5'b10000
  } state_e;

endpackage

// ----- sv/range_min_segment_tree_unit.sv -----
// Top level of the range-minimum segment tree: sequencer, node memory and merge units.
// Depends on rmst_pkg, rmst_node_ram and rmst_merge.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+-------------------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tuser: cmd; tdata: position, new_value,
//           |     |                              |   new_tag, range_low, range_high
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tuser: found; tdata: min_value, min_tag
//  cfg      | in  | cfg_valid_i/cfg_ready_o      | cfg_data_i: active_size
//
// An update does one leaf write, then one parent per level over 10 levels,
// each level one merge and one node-memory write, with the sibling fetched the level before.
// A query does one setup step, one memory read pair per level while the
// bounds still overlap, and one last merge; an ignored update is accepted in the idle state.
// After reset a clearing pass writes all 2048 node entries before s_axis_tready rises.
// A finished query waits in the sequencer only while the output register is full and m_axis_tready is low.
module range_min_segment_tree_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [9:0] position, [41:10] new_value, [51:42] new_tag, [62:52] range_low,
  // [73:63] range_high, rest zero
  input  logic [rmst_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic                              s_axis_tuser,   // [0] cmd
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] min_value, [41:32] min_tag, rest zero
  output logic [rmst_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                              m_axis_tuser,   // [0] found
  // configuration write
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rmst_pkg::SIZE_W-1:0]       cfg_data_i
);
  import rmst_pkg::*;

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic [NODE_W-1:0]   node_q, node_d;
  pair_t               carry_q, carry_d;
  logic [NODE_W-1:0]   lo_q, lo_d;
  logic [NODE_W-1:0]   hi_q, hi_d;
  pair_t               acc_q, acc_d;
  logic                pend_a_q, pend_a_d;
  logic                pend_b_q, pend_b_d;
  logic                out_valid_q, out_valid_d;
  pair_t               out_pair_q, out_pair_d;
  logic                found_q, found_d;
  logic [SIZE_W-1:0]   active_size_q;

  // Input field decode
  logic                in_cmd;
  logic [POS_W-1:0]    in_pos;
  pair_t               in_pair;
  logic [SIZE_W-1:0]   in_lo;
  logic [SIZE_W-1:0]   in_hi;
  logic [SIZE_W-1:0]   hi_clamp;
  logic                upd_ok;

  // Node arithmetic
  logic [NODE_W-1:0]   leaf_node;
  logic [NODE_W-1:0]   leaf_sib;
  logic [NODE_W-1:0]   up_parent;
  logic [NODE_W-1:0]   up_sib;
  logic [NODE_W-1:0]   qry_hi_m1;
  logic [NODE_W-1:0]   qry_lo_next;

  // Memory and merge connections
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  pair_t               ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr_a;
  logic [ADDR_W-1:0]   ram_raddr_b;
  pair_t               rd_a;
  pair_t               rd_b;
  pair_t               mrg_a;
  pair_t               mrg_b;
  pair_t               mrg_min;
  pair_t               acc_min;

  assign in_cmd        = s_axis_tuser;
  assign in_pos        = s_axis_tdata[9:0];
  assign in_pair.value = s_axis_tdata[41:10];
  assign in_pair.tag   = s_axis_tdata[51:42];
  assign in_lo         = s_axis_tdata[62:52];
  assign in_hi         = s_axis_tdata[73:63];

  assign hi_clamp  = (int'(in_hi) > LEAVES) ? SIZE_W'(LEAVES) : in_hi;
  assign upd_ok    = (SIZE_W'(in_pos) < active_size_q) && (int'(in_pos) < LEAVES);

  assign leaf_node   = NODE_W'(LEAVES) + NODE_W'(in_pos);
  assign leaf_sib    = leaf_node ^ NODE_W'(1);
  assign up_parent   = node_q >> 1;
  assign up_sib      = up_parent ^ NODE_W'(1);
  assign qry_hi_m1   = hi_q - NODE_W'(1);
  assign qry_lo_next = (lo_q + NODE_W'(lo_q[0])) >> 1;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  // Node memory
  rmst_node_ram #(
    .DATA_W (PAIR_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // Merge operands: carried pair and sibling on the way up, read nodes during a query
  always_comb begin
    if (state_q == ST_UP) begin
      mrg_a = carry_q;
      mrg_b = rd_a;
    end else begin
      mrg_a = pend_a_q ? rd_a : EMPTY_PAIR;
      mrg_b = pend_b_q ? rd_b : EMPTY_PAIR;
    end
  end

  rmst_merge u_merge_node (
    .a_i   (mrg_a),
    .b_i   (mrg_b),
    .min_o (mrg_min)
  );

  rmst_merge u_merge_acc (
    .a_i   (acc_q),
    .b_i   (mrg_min),
    .min_o (acc_min)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    node_d      = node_q;
    carry_d     = carry_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    acc_d       = acc_q;
    pend_a_d    = 1'b0;
    pend_b_d    = 1'b0;
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_pair_d  = out_pair_q;
    found_d     = found_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = EMPTY_PAIR;
    ram_raddr_a = '0;
    ram_raddr_b = '0;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + ADDR_W'(1);
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (in_cmd == CMD_QUERY) begin
            acc_d   = EMPTY_PAIR;
            state_d = ST_QRY;
            if (in_lo < hi_clamp) begin
              lo_d = NODE_W'(in_lo) + NODE_W'(LEAVES);
              hi_d = NODE_W'(hi_clamp) + NODE_W'(LEAVES);
            end else begin
              lo_d = '0;
              hi_d = '0;
            end
          end else if (upd_ok) begin
            // write the leaf and fetch its sibling for the first parent
            ram_we      = 1'b1;
            ram_waddr   = leaf_node[ADDR_W-1:0];
            ram_wdata   = in_pair;
            ram_raddr_a = leaf_sib[ADDR_W-1:0];
            carry_d     = in_pair;
            node_d      = leaf_node;
            state_d     = ST_UP;
          end
        end
      end

      ST_UP: begin
        // one level per cycle: merge, write parent, fetch parent's sibling
        ram_we      = 1'b1;
        ram_waddr   = up_parent[ADDR_W-1:0];
        ram_wdata   = mrg_min;
        ram_raddr_a = up_sib[ADDR_W-1:0];
        carry_d     = mrg_min;
        node_d      = up_parent;
        if (up_parent == NODE_W'(1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_QRY: begin
        acc_d = acc_min;
        if (lo_q < hi_q) begin
          // odd bounds take their node, then both climb one level
          pend_a_d    = lo_q[0];
          pend_b_d    = hi_q[0];
          ram_raddr_a = lo_q[ADDR_W-1:0];
          ram_raddr_b = qry_hi_m1[ADDR_W-1:0];
          lo_d        = qry_lo_next;
          hi_d        = hi_q >> 1;
        end else if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_pair_d  = acc_min;
          found_d     = (acc_min != EMPTY_PAIR);
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_q         <= '0;
      pend_a_q      <= 1'b0;
      pend_b_q      <= 1'b0;
      out_valid_q   <= 1'b0;
      active_size_q <= ACTIVE_RESET;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pend_a_q    <= pend_a_d;
      pend_b_q    <= pend_b_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        active_size_q <= cfg_data_i;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    node_q     <= node_d;
    carry_q    <= carry_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    acc_q      <= acc_d;
    out_pair_q <= out_pair_d;
    found_q    <= found_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), out_pair_q.tag, out_pair_q.value};
  assign m_axis_tuser  = found_q;

endmodule

// ----- sv/rmst_node_ram.sv -----
// Generic RAM for the tree nodes: one write port, two read ports, registered reads.
// Standalone; no package dependency.
module rmst_node_ram #(
  parameter int DATA_W = 42,
  parameter int ADDR_W = 11
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [DATA_W-1:0] rdata_a_o,
  output logic [DATA_W-1:0] rdata_b_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_a_q;
  logic [DATA_W-1:0] rdata_b_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read ports, old data on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ----- sv/rmst_merge.sv -----
// Pair merge unit: lexicographic minimum, smaller value first, then smaller tag.
// Depends on rmst_pkg.
module rmst_merge (
  input  rmst_pkg::pair_t a_i,
  input  rmst_pkg::pair_t b_i,
  output rmst_pkg::pair_t min_o
);
  import rmst_pkg::*;

  logic b_less;

  // Signed value compare, tag breaks ties
  always_comb begin
    b_less = ($signed(b_i.value) < $signed(a_i.value)) ||
             ((b_i.value == a_i.value) && (b_i.tag < a_i.tag));
    min_o  = b_less ? b_i : a_i;
  end

endmodule

// ----- dv/rmst_result_checker.sv -----
// Result checker for the range-minimum segment tree unit: keeps its own copy of the tree,
// predicts every query result and compares the result stream field by field.
// Depends on rmst_pkg; instantiated by tb beside the unit.
module rmst_result_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input stream, as seen on the unit's slave side
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [rmst_pkg::IN_TDATA_W-1:0]  in_data_i,
  input  logic                             in_cmd_i,
  // result stream, as seen on the unit's master side
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [rmst_pkg::OUT_TDATA_W-1:0] out_data_i,
  input  logic                             out_found_i,
  // configuration write channel
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [rmst_pkg::SIZE_W-1:0]      cfg_data_i,
  output int                               mismatches_o,
  output int                               pending_o
);
  import rmst_pkg::*;

  // Field positions inside the stream data words
  localparam int POS_LSB     = 0;
  localparam int VAL_LSB     = POS_LSB + POS_W;
  localparam int TAG_LSB     = VAL_LSB + VAL_W;
  localparam int LOW_LSB     = TAG_LSB + TAG_W;
  localparam int HIGH_LSB    = LOW_LSB + SIZE_W;
  localparam int OUT_TAG_LSB = VAL_W;
  localparam int OUT_PAD_LSB = VAL_W + TAG_W;

  typedef struct packed {
    logic [VAL_W-1:0] min_value;
    logic [TAG_W-1:0] min_tag;
    logic             found;
  } query_result_t;

  pair_t             tree_nodes [2*LEAVES];
  logic [SIZE_W-1:0] active_slots;
  query_result_t     awaited_results [$];
  int                mismatch_count = 0;
  int                outstanding = 0;

  assign mismatches_o = mismatch_count;
  assign pending_o    = outstanding;

  // Lexicographic minimum: value first, then the smaller tag
  function automatic pair_t lower_pair(input pair_t a, input pair_t b);
    if ($signed(b.value) < $signed(a.value)) return b;
    if ($signed(a.value) < $signed(b.value)) return a;
    return (b.tag < a.tag) ? b : a;
  endfunction

  // Minimum over the half-open slot range, walking the tree bottom-up
  function automatic pair_t range_minimum(input logic [SIZE_W-1:0] low_f,
                                          input logic [SIZE_W-1:0] high_f);
    int    lo;
    int    hi;
    pair_t best;
    lo   = int'(low_f);
    hi   = int'(high_f);
    best = EMPTY_PAIR;
    if (hi > LEAVES) hi = LEAVES;
    if (lo < hi) begin
      lo += LEAVES;
      hi += LEAVES;
      while (lo < hi) begin
        if (lo[0]) begin
          best = lower_pair(best, tree_nodes[lo]);
          lo++;
        end
        if (hi[0]) begin
          hi--;
          best = lower_pair(best, tree_nodes[hi]);
        end
        lo >>= 1;
        hi >>= 1;
      end
    end
    return best;
  endfunction

  // Point write of one leaf, then re-merge every ancestor; slots past the active size are dropped
  task automatic store_pair(input logic [POS_W-1:0] pos, input logic [VAL_W-1:0] val,
                            input logic [TAG_W-1:0] tag);
    int node;
    if (SIZE_W'(pos) >= active_slots) return;
    node = int'(pos) + LEAVES;
    tree_nodes[node].value = val;
    tree_nodes[node].tag   = tag;
    while (node > 1) begin
      node >>= 1;
      tree_nodes[node] = lower_pair(tree_nodes[2*node], tree_nodes[2*node+1]);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] result mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Follow every transaction on the three channels
  always @(posedge clk_i or negedge rst_ni) begin : track
    query_result_t want;
    pair_t         best;
    if (!rst_ni) begin
      for (int n = 0; n < 2*LEAVES; n++) tree_nodes[n] = EMPTY_PAIR;
      active_slots = ACTIVE_RESET;
      awaited_results.delete();
      outstanding = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) active_slots = cfg_data_i;

      // compare a delivered result against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no query pending", 64'(out_data_i), 64'd0);
        end else begin
          want = awaited_results.pop_front();
          if (out_data_i[VAL_W-1:0] !== want.min_value)
            report_mismatch("min_value", 64'(out_data_i[VAL_W-1:0]), 64'(want.min_value));
          if (out_data_i[OUT_TAG_LSB +: TAG_W] !== want.min_tag)
            report_mismatch("min_tag", 64'(out_data_i[OUT_TAG_LSB +: TAG_W]),
                            64'(want.min_tag));
          if (out_found_i !== want.found)
            report_mismatch("found", 64'(out_found_i), 64'(want.found));
          if (out_data_i[OUT_TDATA_W-1:OUT_PAD_LSB] !== '0)
            report_mismatch("tdata padding", 64'(out_data_i[OUT_TDATA_W-1:OUT_PAD_LSB]), 64'd0);
        end
      end

      // apply an accepted command to the tree copy
      if (in_valid_i && in_ready_i) begin
        if (in_cmd_i == CMD_UPDATE) begin
          store_pair(in_data_i[POS_LSB +: POS_W], in_data_i[VAL_LSB +: VAL_W],
                     in_data_i[TAG_LSB +: TAG_W]);
        end else begin
          best           = range_minimum(in_data_i[LOW_LSB +: SIZE_W],
                                         in_data_i[HIGH_LSB +: SIZE_W]);
          want.min_value = best.value;
          want.min_tag   = best.tag;
          want.found     = (best != EMPTY_PAIR);
          awaited_results.push_back(want);
        end
      end
      outstanding = awaited_results.size();
    end
  end

endmodule

// ----- dv/tb.sv -----
// Testbench top for range_min_segment_tree_unit: clock, reset, stimulus, result sink, verdict.
// Depends on rmst_pkg, the unit itself and rmst_result_checker, which does all the checking.
module tb;
  import rmst_pkg::*;

  localparam int          SETTLE_CYCLES = 16;       // longer than one update walk
  localparam int          HOLD_CYCLES   = 400;
  localparam int          CYCLE_LIMIT   = 600000;
  localparam logic [31:0] VALUE_LOWEST  = 32'h8000_0000;
  localparam logic [31:0] VALUE_HIGHEST = 32'h7FFF_FFFF;

  typedef enum int {SINK_OPEN, SINK_HALF, SINK_SPARSE, SINK_DENSE, SINK_PERIODIC} sink_mode_e;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [SIZE_W-1:0]      cfg_data_i;

  int                     mismatches;
  int                     results_waiting;
  int                     cycle_count   = 0;
  int                     hold_requests = 0;
  logic [SIZE_W-1:0]      size_setting  = ACTIVE_RESET;

  range_min_segment_tree_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  rmst_result_checker result_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_cmd_i     (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .out_found_i  (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .mismatches_o (mismatches),
    .pending_o    (results_waiting)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** range_min_segment_tree_unit: FAILED **");
      $finish;
    end
  end

  // Result sink: changing stall patterns, plus a long hold-off whenever one is requested
  initial begin : result_sink
    sink_mode_e mode;
    int         mode_left;
    int         hold_left;
    int         holds_served;
    int         phase;
    mode          = SINK_OPEN;
    mode_left     = 0;
    hold_left     = 0;
    holds_served  = 0;
    phase         = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      phase++;
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_e'($urandom_range(0, 4));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          SINK_OPEN:     m_axis_tready <= 1'b1;
          SINK_HALF:     m_axis_tready <= 1'($urandom_range(0, 1));
          SINK_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
          SINK_DENSE:    m_axis_tready <= ($urandom_range(0, 9) != 0);
          default:       m_axis_tready <= (phase % 5 == 0);
        endcase
      end
    end
  end

  // Offer one command and hold it until the unit takes it; tvalid stays high on return
  task automatic send_item(input logic cmd, input logic [IN_TDATA_W-1:0] data);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Update; the query bounds carry noise that the unit must ignore
  task automatic send_update(input logic [POS_W-1:0] pos, input logic [31:0] val,
                             input logic [TAG_W-1:0] tag);
    logic [SIZE_W-1:0] lo;
    logic [SIZE_W-1:0] hi;
    lo = SIZE_W'($urandom_range(0, LEAVES));
    hi = SIZE_W'($urandom_range(0, LEAVES));
    send_item(CMD_UPDATE, IN_TDATA_W'({hi, lo, tag, val, pos}));
  endtask

  // Query; the update fields carry noise
  task automatic send_query(input logic [SIZE_W-1:0] lo, input logic [SIZE_W-1:0] hi);
    logic [POS_W-1:0] pos;
    logic [31:0]      val;
    logic [TAG_W-1:0] tag;
    pos = POS_W'($urandom);
    val = $urandom;
    tag = TAG_W'($urandom);
    send_item(CMD_QUERY, IN_TDATA_W'({hi, lo, tag, val, pos}));
  endtask

  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Stop offering until every query has answered, then let a trailing update finish
  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (results_waiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_active_size(input logic [SIZE_W-1:0] slots);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= slots;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i  <= 1'b0;
    size_setting = slots;
  endtask

  function automatic int active_span();
    if (size_setting > LEAVES) return LEAVES;
    return int'(size_setting);
  endfunction

  // Mostly inside the active slots, now and then anywhere or just past the end
  function automatic logic [POS_W-1:0] pick_position();
    int span;
    span = active_span();
    if (span == 0 || $urandom_range(0, 4) == 0) return POS_W'($urandom_range(0, LEAVES-1));
    if (span < LEAVES && $urandom_range(0, 9) == 0) return POS_W'(span);
    return POS_W'($urandom_range(0, span-1));
  endfunction

  // Extremes and small values for ties, otherwise anything
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return VALUE_LOWEST;
      1:       return VALUE_HIGHEST;
      2, 3:    return 32'($urandom_range(0, 8)) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [TAG_W-1:0] pick_tag();
    if ($urandom_range(0, 3) == 0) return TAG_W'($urandom_range(0, 3));
    return TAG_W'($urandom_range(0, 1023));
  endfunction

  // Ranges of several shapes: wide, narrow windows, up to the end, empty
  task automatic send_random_query();
    int lo;
    int hi;
    int span;
    span = active_span();
    if (span == 0) span = 8;    // nothing writable: look at the low slots
    case ($urandom_range(0, 5))
      0: begin
        lo = $urandom_range(0, LEAVES);
        hi = $urandom_range(0, LEAVES);
      end
      1: begin
        lo = $urandom_range(0, span-1);
        hi = lo + $urandom_range(1, 8);
      end
      2: begin
        lo = $urandom_range(0, span);
        hi = LEAVES;
      end
      3: begin
        lo = $urandom_range(0, LEAVES);
        hi = $urandom_range(0, lo);
      end
      default: begin
        lo = $urandom_range(0, span);
        hi = $urandom_range(lo, span);
      end
    endcase
    if (hi > LEAVES) hi = LEAVES;
    send_query(SIZE_W'(lo), SIZE_W'(hi));
  endtask

  // Random traffic in bursts; steady phases run back to back with no gaps
  task automatic random_phase(input int count, input bit steady);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && sent < count; b++) begin
        if ($urandom_range(0, 1) != 0) send_update(pick_position(), pick_value(), pick_tag());
        else send_random_query();
        sent++;
      end
      if (steady) gap = 0;
      else begin
        case ($urandom_range(0, 7))
          0, 1:    gap = 0;
          7:       gap = $urandom_range(30, 60);
          default: gap = $urandom_range(1, 12);
        endcase
      end
      idle_gap(gap);
    end
  endtask

  // Main sequence
  initial begin : stimulus
    int phase_sizes [10];
    phase_sizes   = '{1024, 16, 300, 1, 1024, 0, 2047, 513, 1023, 64};
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_UPDATE;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty tree, extremes, tag ties and a stored pair equal to the empty element
    send_query(11'd0, 11'd1024);
    send_update(10'd0, VALUE_LOWEST, 10'd1023);
    send_update(10'd1, VALUE_LOWEST, 10'd0);
    send_update(10'd1023, VALUE_HIGHEST, 10'd0);
    send_update(10'd512, VALUE_HIGHEST, 10'd5);
    send_query(11'd0, 11'd1024);
    send_query(11'd0, 11'd1);
    send_query(11'd1023, 11'd1024);
    send_query(11'd512, 11'd1024);
    idle_gap(3);
    send_query(11'd2, 11'd1024);
    // empty ranges: equal bounds, inverted bounds, at the very end
    send_query(11'd7, 11'd7);
    send_query(11'd900, 11'd3);
    send_query(11'd1024, 11'd1024);
    send_query(11'd1024, 11'd0);
    send_update(10'd1023, 32'hFFFF_FFFF, 10'd1023);
    send_query(11'd1000, 11'd1024);

    // one active slot: writes past it are dropped, older slots still answer
    pause_until_drained();
    write_active_size(11'd1);
    send_update(10'd0, 32'd42, 10'd7);
    send_update(10'd1, 32'hFFFF_FFFB, 10'd3);
    send_update(10'd1023, 32'hFFFF_FFF9, 10'd0);
    send_query(11'd0, 11'd1024);

    // no active slot: every write is dropped
    pause_until_drained();
    write_active_size(11'd0);
    send_update(10'd0, VALUE_LOWEST, 10'd0);
    send_query(11'd0, 11'd2);

    // size register beyond the leaf count
    pause_until_drained();
    write_active_size(11'd2047);
    send_update(10'd1023, VALUE_LOWEST, 10'd1023);
    send_query(11'd0, 11'd1024);

    // random phases over several sizes; two of them start with a long result hold-off
    for (int p = 0; p < 10; p++) begin
      pause_until_drained();
      write_active_size(SIZE_W'(phase_sizes[p]));
      if (p == 2 || p == 7) hold_requests <= hold_requests + 1;
      random_phase(100, p == 0 || p == 2);
    end
    pause_until_drained();
    write_active_size(SIZE_W'($urandom_range(2, LEAVES)));
    random_phase(60, 1'b0);

    pause_until_drained();
    if (mismatches == 0) begin
      $display("** range_min_segment_tree_unit: PASSED **");
    end else begin
      $display("** range_min_segment_tree_unit: FAILED **");
    end
    $finish;
  end

endmodule
